[src/ugcw_pkg.sv]
// Shared types and constants for the graph chain walker.
package ugcw_pkg;

    localparam int MAX_NODES   = 64;
    localparam int MAX_EDGES   = 64;
    localparam int MAX_RESULTS = 64;
    localparam int NODE_W      = $clog2(MAX_NODES);
    localparam int EIDX_W      = $clog2(MAX_EDGES);
    localparam int ECNT_W      = $clog2(MAX_EDGES + 1);
    localparam int KCNT_W      = $clog2(MAX_RESULTS + 1);
    localparam int DEG_W       = 7;
    localparam int REQ_W       = 3;
    localparam int ST_W        = 3;
    localparam int IN_W        = 16;
    localparam int OUT_W       = 24;

    localparam logic [REQ_W-1:0] REQ_ADD_NODE = 3'd0;
    localparam logic [REQ_W-1:0] REQ_ADD_EDGE = 3'd1;
    localparam logic [REQ_W-1:0] REQ_DEGREE   = 3'd2;
    localparam logic [REQ_W-1:0] REQ_NBRS     = 3'd3;
    localparam logic [REQ_W-1:0] REQ_WALK     = 3'd4;

    localparam logic [ST_W-1:0] ST_OK      = 3'd0;
    localparam logic [ST_W-1:0] ST_EXISTS  = 3'd1;
    localparam logic [ST_W-1:0] ST_MISSING = 3'd2;
    localparam logic [ST_W-1:0] ST_DUP     = 3'd3;
    localparam logic [ST_W-1:0] ST_FULL    = 3'd4;
    localparam logic [ST_W-1:0] ST_NONE    = 3'd5;

    localparam logic [2:0] PUT_ST      = 3'd0;
    localparam logic [2:0] PUT_EDGE_OK = 3'd1;
    localparam logic [2:0] PUT_DEG     = 3'd2;
    localparam logic [2:0] PUT_NBR     = 3'd3;
    localparam logic [2:0] PUT_START   = 3'd4;
    localparam logic [2:0] PUT_WALK    = 3'd5;

    typedef struct packed {
        logic [ST_W-1:0]   status;
        logic [NODE_W-1:0] node_out;
        logic [EIDX_W-1:0] edge_index;
        logic              edge_valid;
        logic [DEG_W-1:0]  degree;
    } res_t;

    typedef struct packed {
        logic            load;
        logic            put;
        logic [2:0]      put_sel;
        logic [ST_W-1:0] put_status;
        logic            flush;
        logic            scan_start;
        logic            scan_step;
        logic            add_node;
        logic            add_edge;
        logic            walk_start;
        logic            walk_mark;
        logic            walk_next;
    } cmd_t;

    typedef struct packed {
        logic [REQ_W-1:0] req;
        logic             a_present;
        logic             b_present;
        logic             scan_end;
        logic             touch;
        logic             dup;
        logic             full;
        logic             hits_one;
        logic             k_full;
        logic             pend_valid;
        logic             put_ready;
        logic             flush_ready;
    } stat_t;

endpackage

[src/ugcw_dp.sv]
// Datapath: node bitmaps, edge memory, scan registers, result staging.
module ugcw_dp (
    input  logic                           clk,
    input  logic                           rst_n,
    input  ugcw_pkg::cmd_t                 cmd,
    output ugcw_pkg::stat_t                stat,
    input  logic [ugcw_pkg::REQ_W-1:0]     in_req,
    input  logic [ugcw_pkg::NODE_W-1:0]    in_a,
    input  logic [ugcw_pkg::NODE_W-1:0]    in_b,
    output logic                           out_valid,
    input  logic                           out_ready,
    output ugcw_pkg::res_t                 out_res,
    output logic                           out_last,
    output logic [ugcw_pkg::ECNT_W-1:0]    edge_count
);

    logic [ugcw_pkg::REQ_W-1:0]  req_reg;
    logic [ugcw_pkg::NODE_W-1:0] a_reg;
    logic [ugcw_pkg::NODE_W-1:0] b_reg;
    logic [ugcw_pkg::NODE_W-1:0] cur_reg;
    logic [ugcw_pkg::MAX_NODES-1:0] present_reg;
    logic [ugcw_pkg::MAX_NODES-1:0] visited_reg;
    logic [ugcw_pkg::ECNT_W-1:0] ecnt_reg;
    logic [ugcw_pkg::ECNT_W-1:0] idx_reg;
    logic [ugcw_pkg::DEG_W-1:0]  deg_reg;
    logic                        dup_reg;
    logic [1:0]                  hits_reg;
    logic [ugcw_pkg::EIDX_W-1:0] pick_e_reg;
    logic [ugcw_pkg::NODE_W-1:0] pick_n_reg;
    logic [ugcw_pkg::KCNT_W-1:0] k_reg;
    logic                        pend_v_reg;
    ugcw_pkg::res_t              pend_reg;
    logic                        out_v_reg;
    logic                        out_last_reg;
    ugcw_pkg::res_t              out_reg;

    logic [2*ugcw_pkg::NODE_W-1:0] edge_mem [0:ugcw_pkg::MAX_EDGES-1];
    logic [2*ugcw_pkg::NODE_W-1:0] mem_q;

    logic [ugcw_pkg::NODE_W-1:0] ea;
    logic [ugcw_pkg::NODE_W-1:0] eb;
    logic [ugcw_pkg::NODE_W-1:0] other;
    logic                        touch;
    logic                        dup_m;
    logic                        put_ready;
    logic                        flush_ready;
    ugcw_pkg::res_t              new_res;

    assign ea    = mem_q[ugcw_pkg::NODE_W-1:0];
    assign eb    = mem_q[2*ugcw_pkg::NODE_W-1:ugcw_pkg::NODE_W];
    assign touch = (ea == cur_reg) || (eb == cur_reg);
    assign other = (ea == cur_reg) ? eb : ea;
    assign dup_m = ((ea == a_reg) && (eb == b_reg)) || ((ea == b_reg) && (eb == a_reg));

    assign put_ready   = !pend_v_reg || !out_v_reg || out_ready;
    assign flush_ready = !out_v_reg || out_ready;

    always_comb
    begin
        new_res = '0;
        new_res.status = ugcw_pkg::ST_OK;
        case (cmd.put_sel)
            ugcw_pkg::PUT_ST:
            begin
                new_res.status = cmd.put_status;
            end
            ugcw_pkg::PUT_EDGE_OK:
            begin
                new_res.edge_index = ecnt_reg[ugcw_pkg::EIDX_W-1:0];
                new_res.edge_valid = 1'b1;
            end
            ugcw_pkg::PUT_DEG:
            begin
                new_res.degree = deg_reg;
            end
            ugcw_pkg::PUT_NBR:
            begin
                new_res.node_out   = other;
                new_res.edge_index = idx_reg[ugcw_pkg::EIDX_W-1:0];
                new_res.edge_valid = 1'b1;
            end
            ugcw_pkg::PUT_START:
            begin
                new_res.node_out = cur_reg;
            end
            ugcw_pkg::PUT_WALK:
            begin
                new_res.node_out   = pick_n_reg;
                new_res.edge_index = pick_e_reg;
                new_res.edge_valid = 1'b1;
            end
            default:
            begin
                new_res.status = ugcw_pkg::ST_NONE;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (cmd.add_edge)
        begin
            edge_mem[ecnt_reg[ugcw_pkg::EIDX_W-1:0]] <= {b_reg, a_reg};
        end
        mem_q <= edge_mem[idx_reg[ugcw_pkg::EIDX_W-1:0]];
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            req_reg <= in_req;
            a_reg   <= in_a;
            b_reg   <= in_b;
        end
        if (cmd.put)
        begin
            pend_reg <= new_res;
            if (pend_v_reg)
            begin
                out_reg      <= pend_reg;
                out_last_reg <= 1'b0;
            end
        end
        else if (cmd.flush)
        begin
            out_reg      <= pend_reg;
            out_last_reg <= 1'b1;
        end
        if (cmd.scan_step && touch && !visited_reg[other] && (hits_reg == 2'd0))
        begin
            pick_e_reg <= idx_reg[ugcw_pkg::EIDX_W-1:0];
            pick_n_reg <= other;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            present_reg <= '0;
            visited_reg <= '0;
            ecnt_reg    <= '0;
            idx_reg     <= '0;
            deg_reg     <= '0;
            dup_reg     <= 1'b0;
            hits_reg    <= 2'd0;
            k_reg       <= '0;
            cur_reg     <= '0;
            pend_v_reg  <= 1'b0;
            out_v_reg   <= 1'b0;
        end
        else
        begin
            if (cmd.load)
            begin
                cur_reg <= in_a;
            end
            if (cmd.add_node)
            begin
                present_reg[a_reg] <= 1'b1;
            end
            if (cmd.add_edge)
            begin
                ecnt_reg <= ecnt_reg + 1'b1;
            end
            if (cmd.walk_start)
            begin
                visited_reg <= '0;
                k_reg       <= ugcw_pkg::KCNT_W'(1);
            end
            if (cmd.walk_mark)
            begin
                visited_reg[cur_reg] <= 1'b1;
            end
            if (cmd.walk_next)
            begin
                cur_reg <= pick_n_reg;
                k_reg   <= k_reg + 1'b1;
            end
            if (cmd.scan_start)
            begin
                idx_reg  <= '0;
                deg_reg  <= '0;
                dup_reg  <= 1'b0;
                hits_reg <= 2'd0;
            end
            else if (cmd.scan_step)
            begin
                idx_reg <= idx_reg + 1'b1;
                if (touch)
                begin
                    deg_reg <= deg_reg + 1'b1;
                end
                if (dup_m)
                begin
                    dup_reg <= 1'b1;
                end
                if (touch && !visited_reg[other] && (hits_reg != 2'd2))
                begin
                    hits_reg <= hits_reg + 1'b1;
                end
            end
            if (cmd.put)
            begin
                pend_v_reg <= 1'b1;
            end
            else if (cmd.flush)
            begin
                pend_v_reg <= 1'b0;
            end
            if ((cmd.put && pend_v_reg) || cmd.flush)
            begin
                out_v_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_v_reg <= 1'b0;
            end
        end
    end

    always_comb
    begin
        stat.req         = req_reg;
        stat.a_present   = present_reg[a_reg];
        stat.b_present   = present_reg[b_reg];
        stat.scan_end    = (idx_reg == ecnt_reg);
        stat.touch       = touch;
        stat.dup         = dup_reg;
        stat.full        = (ecnt_reg == ugcw_pkg::ECNT_W'(ugcw_pkg::MAX_EDGES));
        stat.hits_one    = (hits_reg == 2'd1);
        stat.k_full      = (k_reg >= ugcw_pkg::KCNT_W'(ugcw_pkg::MAX_RESULTS));
        stat.pend_valid  = pend_v_reg;
        stat.put_ready   = put_ready;
        stat.flush_ready = flush_ready;
    end

    assign out_valid  = out_v_reg;
    assign out_res    = out_reg;
    assign out_last   = out_last_reg;
    assign edge_count = ecnt_reg;

endmodule

[src/ugcw_ctrl.sv]
// Controller: request decode, edge scan, walk step and result flush sequencing.
module ugcw_ctrl (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            in_valid,
    output logic            in_ready,
    input  ugcw_pkg::stat_t stat,
    output ugcw_pkg::cmd_t  cmd
);

    localparam logic [2:0] S_IDLE    = 3'd0;
    localparam logic [2:0] S_DECODE  = 3'd1;
    localparam logic [2:0] S_SCAN_RD = 3'd2;
    localparam logic [2:0] S_SCAN_EV = 3'd3;
    localparam logic [2:0] S_SCAN_END = 3'd4;
    localparam logic [2:0] S_WMARK   = 3'd5;
    localparam logic [2:0] S_FLUSH   = 3'd6;

    logic [2:0] state_reg;
    logic [2:0] state_next;

    always_comb
    begin
        cmd        = '0;
        state_next = state_reg;
        in_ready   = 1'b0;
        case (state_reg)
            S_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = S_DECODE;
                end
            end
            S_DECODE:
            begin
                case (stat.req)
                    ugcw_pkg::REQ_ADD_NODE:
                    begin
                        cmd.put        = 1'b1;
                        cmd.put_sel    = ugcw_pkg::PUT_ST;
                        cmd.put_status = stat.a_present ? ugcw_pkg::ST_EXISTS : ugcw_pkg::ST_OK;
                        cmd.add_node   = !stat.a_present;
                        state_next     = S_FLUSH;
                    end
                    ugcw_pkg::REQ_ADD_EDGE:
                    begin
                        if (stat.a_present && stat.b_present)
                        begin
                            cmd.scan_start = 1'b1;
                            state_next     = S_SCAN_RD;
                        end
                        else
                        begin
                            cmd.put        = 1'b1;
                            cmd.put_sel    = ugcw_pkg::PUT_ST;
                            cmd.put_status = ugcw_pkg::ST_MISSING;
                            state_next     = S_FLUSH;
                        end
                    end
                    ugcw_pkg::REQ_DEGREE, ugcw_pkg::REQ_NBRS:
                    begin
                        cmd.scan_start = 1'b1;
                        state_next     = S_SCAN_RD;
                    end
                    ugcw_pkg::REQ_WALK:
                    begin
                        cmd.put = 1'b1;
                        if (stat.a_present)
                        begin
                            cmd.put_sel    = ugcw_pkg::PUT_START;
                            cmd.walk_start = 1'b1;
                            state_next     = S_WMARK;
                        end
                        else
                        begin
                            cmd.put_sel    = ugcw_pkg::PUT_ST;
                            cmd.put_status = ugcw_pkg::ST_MISSING;
                            state_next     = S_FLUSH;
                        end
                    end
                    default:
                    begin
                        cmd.put        = 1'b1;
                        cmd.put_sel    = ugcw_pkg::PUT_ST;
                        cmd.put_status = ugcw_pkg::ST_NONE;
                        state_next     = S_FLUSH;
                    end
                endcase
            end
            S_WMARK:
            begin
                cmd.walk_mark  = 1'b1;
                cmd.scan_start = 1'b1;
                state_next     = S_SCAN_RD;
            end
            S_SCAN_RD:
            begin
                state_next = stat.scan_end ? S_SCAN_END : S_SCAN_EV;
            end
            S_SCAN_EV:
            begin
                if (stat.req == ugcw_pkg::REQ_NBRS && stat.touch)
                begin
                    if (stat.put_ready)
                    begin
                        cmd.put       = 1'b1;
                        cmd.put_sel   = ugcw_pkg::PUT_NBR;
                        cmd.scan_step = 1'b1;
                        state_next    = S_SCAN_RD;
                    end
                end
                else
                begin
                    cmd.scan_step = 1'b1;
                    state_next    = S_SCAN_RD;
                end
            end
            S_SCAN_END:
            begin
                case (stat.req)
                    ugcw_pkg::REQ_ADD_EDGE:
                    begin
                        cmd.put    = 1'b1;
                        state_next = S_FLUSH;
                        if (stat.dup)
                        begin
                            cmd.put_sel    = ugcw_pkg::PUT_ST;
                            cmd.put_status = ugcw_pkg::ST_DUP;
                        end
                        else if (stat.full)
                        begin
                            cmd.put_sel    = ugcw_pkg::PUT_ST;
                            cmd.put_status = ugcw_pkg::ST_FULL;
                        end
                        else
                        begin
                            cmd.put_sel  = ugcw_pkg::PUT_EDGE_OK;
                            cmd.add_edge = 1'b1;
                        end
                    end
                    ugcw_pkg::REQ_DEGREE:
                    begin
                        cmd.put     = 1'b1;
                        cmd.put_sel = ugcw_pkg::PUT_DEG;
                        state_next  = S_FLUSH;
                    end
                    ugcw_pkg::REQ_NBRS:
                    begin
                        if (!stat.pend_valid)
                        begin
                            cmd.put        = 1'b1;
                            cmd.put_sel    = ugcw_pkg::PUT_ST;
                            cmd.put_status = ugcw_pkg::ST_NONE;
                        end
                        state_next = S_FLUSH;
                    end
                    ugcw_pkg::REQ_WALK:
                    begin
                        if (stat.hits_one && !stat.k_full)
                        begin
                            if (stat.put_ready)
                            begin
                                cmd.put       = 1'b1;
                                cmd.put_sel   = ugcw_pkg::PUT_WALK;
                                cmd.walk_next = 1'b1;
                                state_next    = S_WMARK;
                            end
                        end
                        else
                        begin
                            state_next = S_FLUSH;
                        end
                    end
                    default:
                    begin
                        state_next = S_FLUSH;
                    end
                endcase
            end
            S_FLUSH:
            begin
                if (stat.flush_ready)
                begin
                    cmd.flush  = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

[src/undirected_graph_chain_walker_top.sv]
// Top level of the undirected graph store with chain walker.
// One request is taken at a time. Add edge with both nodes present, degree and
// neighbours requests scan the edge list once, and a walk from a present node
// scans it once per node reached; each stored edge is read in S_SCAN_RD and
// evaluated in S_SCAN_EV, through the single read port of the edge memory. A
// finished result waits in the output register, a second in a staging
// register, so a stalled output side only pauses the scan.
module undirected_graph_chain_walker_top (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [15:0] s_axis_tdata,   // req_type[2:0], node_a[8:3], node_b[14:9], zero pad
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [23:0] m_axis_tdata,   // status[2:0], node_out[8:3], edge_index[14:9],
                                        // edge_valid[15], degree[22:16], zero pad
    output logic        m_axis_tlast
);

    ugcw_pkg::cmd_t  cmd;
    ugcw_pkg::stat_t stat;
    ugcw_pkg::res_t  res;
    logic [ugcw_pkg::ECNT_W-1:0] edge_count;

    ugcw_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_axis_tvalid),
        .in_ready (s_axis_tready),
        .stat     (stat),
        .cmd      (cmd)
    );

    ugcw_dp u_dp (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd        (cmd),
        .stat       (stat),
        .in_req     (s_axis_tdata[2:0]),
        .in_a       (s_axis_tdata[8:3]),
        .in_b       (s_axis_tdata[14:9]),
        .out_valid  (m_axis_tvalid),
        .out_ready  (m_axis_tready),
        .out_res    (res),
        .out_last   (m_axis_tlast),
        .edge_count (edge_count)
    );

    assign m_axis_tdata = {1'b0, res.degree, res.edge_valid, res.edge_index,
                           res.node_out, res.status};

`ifndef SYNTH
    a_busy_after_take: assert property (@(posedge clk) disable iff (!rst_n)
        (s_axis_tvalid && s_axis_tready) |=> !s_axis_tready)
        else $error("request taken while busy");

    a_edge_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        edge_count <= ugcw_pkg::ECNT_W'(ugcw_pkg::MAX_EDGES))
        else $error("edge count overflow");

    a_edge_valid_ok: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && m_axis_tdata[15]) |-> (m_axis_tdata[2:0] == ugcw_pkg::ST_OK))
        else $error("edge index with error status");
`endif

endmodule
